### rtl/tst_pkg.sv
// shared types and constants for the type signature tokenizer
`default_nettype none

package tst_pkg;

   localparam int POS_W = 17;
   localparam int CNT_W = 31;
   localparam int PROD_W = 2 * CNT_W;

   localparam logic [POS_W-1:0] MAX_LENGTH = 17'd65535;

   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_AGG_OPEN  = 8'h3C;
   localparam logic [7:0] CH_AGG_CLOSE = 8'h3E;
   localparam logic [7:0] CH_IDX_OPEN  = 8'h5B;
   localparam logic [7:0] CH_IDX_CLOSE = 8'h5D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [CNT_W-1:0] ACC_LIMIT = 31'd214748364;
   localparam logic [3:0] ACC_LAST = 4'd7;

   typedef enum logic [1:0] {
      OUTCOME_TOKEN      = 2'd0,
      OUTCOME_OPEN_AGG   = 2'd1,
      OUTCOME_BAD_SUFFIX = 2'd2
   } tst_outcome_type;

   typedef struct packed {
      tst_outcome_type   outcome;
      logic [POS_W-1:0]  span_start;
      logic [POS_W-1:0]  type_stop;
      logic [POS_W-1:0]  span_stop;
      logic [CNT_W-1:0]  element_count;
      logic              closes_string;
   } tst_result_type;

   typedef struct packed {
      logic           first_valid;
      logic           second_valid;
      tst_result_type first;
      tst_result_type second;
   } tst_push_type;

endpackage

`default_nettype wire

### rtl/type_signature_tokenizer_core.sv
// type signature tokenizer: top level with scanner, result queue and checks
//
// request channel: one signature byte per transaction on req_tdata, with
// req_tlast high on the final byte of a string
// response channel: one token or error per transaction; rsp_tuser is the
// outcome (token, unclosed aggregate, bad array suffix), rsp_tlast marks
// the final response of a string
// a byte produces zero, one or two responses; they enter a four-entry
// queue that registers them, and they reach rsp_tvalid behind any older ones
// throughput is one byte per cycle while the queue has room; the scanner
// state is registered once per byte, the longest path being the 31 by 31
// bit count multiply at a closing bracket
// req_tready is high while the queue has room for two responses, so a
// stalled receiver holds up the request side once three responses wait
// reset clears the scanner state and empties the queue; positions start
// again at one with the next byte
`default_nettype none

module type_signature_tokenizer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_byte
   input  wire logic        req_tlast,   // final_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // span_start, type_stop, span_stop, element_count
   output logic [1:0]       rsp_tuser,   // outcome
   output logic             rsp_tlast    // closes_string
);
   import tst_pkg::*;

   logic           fire;
   logic           pop;
   logic           has_room;
   tst_push_type   push;
   tst_result_type head;

   assign fire = req_tvalid && req_tready;
   assign pop  = rsp_tvalid && rsp_tready;
   assign req_tready = has_room;

   tst_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .char_byte  (req_tdata),
      .final_byte (req_tlast),
      .push       (push)
   );

   tst_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_tvalid),
      .has_room  (has_room)
   );

   assign rsp_tdata = {6'b000000, head.element_count, head.span_stop,
                       head.type_stop, head.span_start};
   assign rsp_tuser = head.outcome;
   assign rsp_tlast = head.closes_string;

   a_push_needs_transaction: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> fire)
      else $error("response produced without a request transaction");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid)
      else $error("second response without a first");

   a_second_closes: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.second.closes_string)
      else $error("second response does not close the string");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != 2'(OUTCOME_TOKEN))) |-> rsp_tlast)
      else $error("error response does not close the string");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

### rtl/tst_scan.sv
// per-byte scanner: token state registers and result generation
`default_nettype none

module tst_scan (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [7:0]           char_byte,
   input  wire logic                 final_byte,
   output tst_pkg::tst_push_type     push
);
   import tst_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_STARS   = 3'd1,
      PH_AGG     = 3'd2,
      PH_AFTER   = 3'd3,
      PH_DIGITS  = 3'd4,
      PH_DISCARD = 3'd5
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  tok_begin_ff, tok_begin_in;
   logic [POS_W-1:0]  type_stop_ff, type_stop_in;
   logic [POS_W-1:0]  brk_begin_ff, brk_begin_in;
   logic [CNT_W-1:0]  accum_ff, accum_in;
   logic              seen_ff, seen_in;
   logic              bad_ff, bad_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [POS_W-1:0]  next_pos;
   logic [PROD_W-1:0] product;
   logic              is_digit;
   logic [3:0]        digit;
   logic [CNT_W-1:0]  accum_next;
   tst_result_type    res0, res1;
   logic              res0_valid, res1_valid;

   assign next_pos   = pos_ff + 17'd1;
   assign product    = PROD_W'(count_ff) * PROD_W'(accum_ff);
   assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
   assign digit      = char_byte[3:0];
   assign accum_next = {accum_ff[CNT_W-4:0], 3'b000} + {accum_ff[CNT_W-2:0], 1'b0}
                       + CNT_W'(digit);

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tok_begin_in = tok_begin_ff;
      type_stop_in = type_stop_ff;
      brk_begin_in = brk_begin_ff;
      accum_in     = accum_ff;
      seen_in      = seen_ff;
      bad_in       = bad_ff;
      count_in     = count_ff;
      res0         = '0;
      res1         = '0;
      res0_valid   = 1'b0;
      res1_valid   = 1'b0;

      if (pos_ff < MAX_LENGTH) begin
         pos_in = next_pos;
         case (phase_ff)
            PH_IDLE: begin
               tok_begin_in = next_pos;
               count_in     = 31'd1;
               if (char_byte == CH_STAR) begin
                  phase_in = PH_STARS;
               end else if (char_byte == CH_AGG_OPEN) begin
                  phase_in = PH_AGG;
               end else begin
                  type_stop_in = next_pos;
                  phase_in     = PH_AFTER;
               end
            end
            PH_STARS: begin
               if (char_byte != CH_STAR) begin
                  count_in = 31'd1;
                  if (char_byte == CH_AGG_OPEN) begin
                     phase_in = PH_AGG;
                  end else begin
                     type_stop_in = next_pos;
                     phase_in     = PH_AFTER;
                  end
               end
            end
            PH_AGG: begin
               if (char_byte == CH_AGG_CLOSE) begin
                  type_stop_in = next_pos;
                  phase_in     = PH_AFTER;
               end
            end
            PH_AFTER: begin
               if (char_byte == CH_IDX_OPEN) begin
                  brk_begin_in = next_pos;
                  accum_in     = '0;
                  seen_in      = 1'b0;
                  bad_in       = 1'b0;
                  phase_in     = PH_DIGITS;
               end else begin
                  res0_valid         = 1'b1;
                  res0.outcome       = OUTCOME_TOKEN;
                  res0.span_start    = tok_begin_ff;
                  res0.type_stop     = type_stop_ff;
                  res0.span_stop     = pos_ff;
                  res0.element_count = count_ff;
                  tok_begin_in       = next_pos;
                  count_in           = 31'd1;
                  if (char_byte == CH_STAR) begin
                     phase_in = PH_STARS;
                  end else if (char_byte == CH_AGG_OPEN) begin
                     phase_in = PH_AGG;
                  end else begin
                     type_stop_in = next_pos;
                     phase_in     = PH_AFTER;
                  end
               end
            end
            PH_DIGITS: begin
               if (char_byte == CH_IDX_CLOSE) begin
                  if (bad_ff || !seen_ff || (product[PROD_W-1:CNT_W] != '0)) begin
                     res0_valid         = 1'b1;
                     res0.outcome       = OUTCOME_BAD_SUFFIX;
                     res0.span_start    = brk_begin_ff;
                     res0.span_stop     = next_pos;
                     res0.closes_string = 1'b1;
                     phase_in           = PH_DISCARD;
                  end else begin
                     count_in = product[CNT_W-1:0];
                     phase_in = PH_AFTER;
                  end
               end else if (!bad_ff) begin
                  if (!is_digit) begin
                     bad_in = 1'b1;
                  end else begin
                     if (!seen_ff && (digit == 4'd0)) begin
                        bad_in = 1'b1;
                     end else if ((accum_ff > ACC_LIMIT) ||
                                  ((accum_ff == ACC_LIMIT) && (digit > ACC_LAST))) begin
                        bad_in = 1'b1;
                     end else begin
                        accum_in = accum_next;
                     end
                     seen_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (final_byte) begin
         case (phase_in)
            PH_STARS: begin
               res1_valid         = 1'b1;
               res1.outcome       = OUTCOME_TOKEN;
               res1.span_start    = tok_begin_in;
               res1.type_stop     = pos_in;
               res1.span_stop     = pos_in;
               res1.element_count = 31'd1;
            end
            PH_AGG: begin
               res1_valid      = 1'b1;
               res1.outcome    = OUTCOME_OPEN_AGG;
               res1.span_start = tok_begin_in;
               res1.span_stop  = pos_in + 17'd1;
            end
            PH_AFTER: begin
               res1_valid         = 1'b1;
               res1.outcome       = OUTCOME_TOKEN;
               res1.span_start    = tok_begin_in;
               res1.type_stop     = type_stop_in;
               res1.span_stop     = pos_in;
               res1.element_count = count_in;
            end
            PH_DIGITS: begin
               res1_valid      = 1'b1;
               res1.outcome    = OUTCOME_BAD_SUFFIX;
               res1.span_start = tok_begin_in;
               res1.span_stop  = pos_in;
            end
            default: begin
            end
         endcase
         res1.closes_string = 1'b1;
         if (!res1_valid) begin
            res0.closes_string = 1'b1;
         end
         phase_in     = PH_IDLE;
         pos_in       = '0;
         tok_begin_in = '0;
         type_stop_in = '0;
         brk_begin_in = '0;
         accum_in     = '0;
         seen_in      = 1'b0;
         bad_in       = 1'b0;
         count_in     = 31'd1;
      end
   end

   always_comb begin
      push.first_valid  = fire && (res0_valid || res1_valid);
      push.second_valid = fire && res0_valid && res1_valid;
      push.first        = res0_valid ? res0 : res1;
      push.second       = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         tok_begin_ff <= '0;
         type_stop_ff <= '0;
         brk_begin_ff <= '0;
         accum_ff     <= '0;
         seen_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         count_ff     <= 31'd1;
      end else if (fire) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tok_begin_ff <= tok_begin_in;
         type_stop_ff <= type_stop_in;
         brk_begin_ff <= brk_begin_in;
         accum_ff     <= accum_in;
         seen_ff      <= seen_in;
         bad_ff       <= bad_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tst_rsp_queue.sv
// four-entry result queue, takes up to two results per cycle
`default_nettype none

module tst_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tst_pkg::tst_push_type push,
   input  wire logic                  pop,
   output tst_pkg::tst_result_type    head,
   output logic                       not_empty,
   output logic                       has_room
);
   import tst_pkg::*;

   tst_result_type entry_ff [4];
   logic [1:0]     head_ff, head_in;
   logic [1:0]     tail_ff, tail_in;
   logic [2:0]     fill_ff, fill_in;
   logic [1:0]     push_n;

   assign push_n    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign head      = entry_ff[head_ff];
   assign not_empty = (fill_ff != 3'd0);
   assign has_room  = (fill_ff <= 3'd2);

   always_comb begin
      head_in = head_ff + {1'b0, pop};
      tail_in = tail_ff + push_n;
      fill_in = fill_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[tail_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

### dv/type_signature_tokenizer_core_tb.sv
// testbench for type_signature_tokenizer_core: directed and random signature strings checked against a byte-level token predictor
`timescale 1ns / 1ps

module type_signature_tokenizer_core_tb;
   import tst_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int unsigned COUNT_MAX = 32'd2147483647;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_STARS,
      SCAN_AGG,
      SCAN_AFTER,
      SCAN_DIGITS,
      SCAN_DISCARD
   } scan_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   type_signature_tokenizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // token predictor state
   scan_phase_type scan_phase;
   int unsigned    byte_pos;
   int unsigned    tok_begin;
   int unsigned    type_pos;
   int unsigned    bracket_pos;
   int unsigned    digit_value;
   int unsigned    tok_count;
   logic           have_digit;
   logic           digit_bad;

   tst_result_type expected_tokens[$];
   tst_result_type want_token;
   logic [7:0]     sig_bytes[$];

   int          mismatch_count = 0;
   int          cycle_count = 0;
   int unsigned sent_bytes = 0;
   int          rsp_hold = 0;
   logic        calm_mode = 1'b0;

   function automatic void reset_scan();
      scan_phase = SCAN_IDLE;
      byte_pos = 0;
      tok_begin = 0;
      type_pos = 0;
      bracket_pos = 0;
      digit_value = 0;
      have_digit = 1'b0;
      digit_bad = 1'b0;
      tok_count = 1;
   endfunction

   function automatic void push_token(input tst_outcome_type outcome, input int unsigned first,
                                      input int unsigned type_last, input int unsigned last,
                                      input int unsigned count, input logic closes);
      tst_result_type r;
      r.outcome = outcome;
      r.span_start = first[POS_W-1:0];
      r.type_stop = type_last[POS_W-1:0];
      r.span_stop = last[POS_W-1:0];
      r.element_count = count[CNT_W-1:0];
      r.closes_string = closes;
      expected_tokens.push_back(r);
   endfunction

   function automatic void open_token(input logic [7:0] ch, input int unsigned p);
      tok_begin = p;
      tok_count = 1;
      if (ch == CH_STAR) begin
         scan_phase = SCAN_STARS;
      end else if (ch == CH_AGG_OPEN) begin
         scan_phase = SCAN_AGG;
      end else begin
         type_pos = p;
         scan_phase = SCAN_AFTER;
      end
   endfunction

   function automatic void tokenize_byte(input logic [7:0] ch, input logic last);
      int unsigned     p;
      int unsigned     digit;
      longint unsigned product;
      int              first_new;
      tst_result_type  tail;
      first_new = expected_tokens.size();
      if (byte_pos < MAX_LENGTH) begin
         byte_pos = byte_pos + 1;
         p = byte_pos;
         case (scan_phase)
            SCAN_IDLE: open_token(ch, p);
            SCAN_STARS: begin
               // stars keep the token start; the type part follows them
               if (ch != CH_STAR) begin
                  tok_count = 1;
                  if (ch == CH_AGG_OPEN) begin
                     scan_phase = SCAN_AGG;
                  end else begin
                     type_pos = p;
                     scan_phase = SCAN_AFTER;
                  end
               end
            end
            SCAN_AGG: begin
               if (ch == CH_AGG_CLOSE) begin
                  type_pos = p;
                  scan_phase = SCAN_AFTER;
               end
            end
            SCAN_AFTER: begin
               if (ch == CH_IDX_OPEN) begin
                  bracket_pos = p;
                  digit_value = 0;
                  have_digit = 1'b0;
                  digit_bad = 1'b0;
                  scan_phase = SCAN_DIGITS;
               end else begin
                  push_token(OUTCOME_TOKEN, tok_begin, type_pos, p - 1, tok_count, 1'b0);
                  open_token(ch, p);
               end
            end
            SCAN_DIGITS: begin
               if (ch == CH_IDX_CLOSE) begin
                  product = tok_count;
                  product = product * digit_value;
                  if (digit_bad || !have_digit || product > COUNT_MAX) begin
                     push_token(OUTCOME_BAD_SUFFIX, bracket_pos, 0, p, 0, 1'b1);
                     scan_phase = SCAN_DISCARD;
                  end else begin
                     tok_count = product[31:0];
                     scan_phase = SCAN_AFTER;
                  end
               end else if (!digit_bad) begin
                  if (ch < CH_ZERO || ch > CH_NINE) begin
                     digit_bad = 1'b1;
                  end else begin
                     digit = ch - CH_ZERO;
                     if (!have_digit && digit == 0) begin
                        digit_bad = 1'b1;
                     end else if (digit_value > ACC_LIMIT ||
                                  (digit_value == ACC_LIMIT && digit > ACC_LAST)) begin
                        digit_bad = 1'b1;
                     end else begin
                        digit_value = digit_value * 10 + digit;
                     end
                     have_digit = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (last) begin
         case (scan_phase)
            SCAN_STARS: push_token(OUTCOME_TOKEN, tok_begin, byte_pos, byte_pos, 1, 1'b0);
            SCAN_AGG:   push_token(OUTCOME_OPEN_AGG, tok_begin, 0, byte_pos + 1, 0, 1'b1);
            SCAN_AFTER: push_token(OUTCOME_TOKEN, tok_begin, type_pos, byte_pos, tok_count, 1'b0);
            SCAN_DIGITS: push_token(OUTCOME_BAD_SUFFIX, tok_begin, 0, byte_pos, 0, 1'b1);
            default: ;
         endcase
         if (expected_tokens.size() > first_new) begin
            tail = expected_tokens.pop_back();
            tail.closes_string = 1'b1;
            expected_tokens.push_back(tail);
         end
         reset_scan();
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // transaction monitor: predict on accepted bytes, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("response with no token expected: tuser %0d tdata %h", rsp_tuser,
                      rsp_tdata);
               mismatch_count++;
            end else begin
               want_token = expected_tokens.pop_front();
               compare_field("outcome", want_token.outcome, rsp_tuser);
               compare_field("span_start", want_token.span_start, rsp_tdata[16:0]);
               compare_field("type_stop", want_token.type_stop, rsp_tdata[33:17]);
               compare_field("span_stop", want_token.span_stop, rsp_tdata[50:34]);
               compare_field("element_count", want_token.element_count, rsp_tdata[81:51]);
               compare_field("closes_string", want_token.closes_string, rsp_tlast);
            end
         end
      end
   end

   // receiver backpressure in random bursts, with no new bursts in calm mode
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!calm_mode && $urandom_range(0, 9) == 0) begin
         rsp_hold <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("type_signature_tokenizer_core verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      begin
         gap = 0;
         if (!calm_mode && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
         end
         @(negedge clock);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= data;
         req_tlast <= last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent_bytes++;
      end
   endtask

   task automatic send_signature();
      int i;
      begin
         for (i = 0; i < sig_bytes.size(); i++) begin
            send_byte(sig_bytes[i], i == sig_bytes.size() - 1);
         end
         sig_bytes.delete();
      end
   endtask

   task automatic add_text(input string s);
      int i;
      begin
         for (i = 0; i < s.len(); i++) begin
            sig_bytes.push_back(s[i]);
         end
      end
   endtask

   task automatic run_text(input string s);
      begin
         add_text(s);
         send_signature();
      end
   endtask

   task automatic add_number(input int unsigned n);
      logic [7:0] digits[$];
      int i;
      begin
         do begin
            digits.push_front(8'(CH_ZERO + n % 10));
            n = n / 10;
         end while (n != 0);
         for (i = 0; i < digits.size(); i++) begin
            sig_bytes.push_back(digits[i]);
         end
      end
   endtask

   task automatic wait_for_drain();
      begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (expected_tokens.size() != 0) @(posedge clock);
      end
   endtask

   task automatic test_plain_tokens();
      begin
         sig_bytes.push_back(8'h00);
         send_signature();
         sig_bytes.push_back(8'hFF);
         send_signature();
         run_text("i");
         run_text("ab");
         run_text("*i");
         run_text("***");
         run_text("**<ab>[3][4]");
         run_text("c[2147483647]");
         run_text("<<a>>");
         wait_for_drain();
      end
   endtask

   task automatic test_open_aggregates();
      begin
         run_text("<abc");
         run_text("i*<");
         wait_for_drain();
      end
   endtask

   task automatic test_bad_suffixes();
      begin
         run_text("i[]");
         run_text("i[01]");
         run_text("i[a]");
         run_text("i[2147483648]");
         run_text("i[99999999999]");
         run_text("i[65536][32768]");
         run_text("i[12");
         run_text("i[0x");
         run_text("i[]zz");
         wait_for_drain();
      end
   endtask

   task automatic build_random_signature();
      int         tokens;
      int         len;
      int         sufs;
      int         pick;
      logic [7:0] b;
      begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               b = 8'($urandom_range(0, 255));
               sig_bytes.push_back(b);
            end
         end else begin
            tokens = $urandom_range(1, 4);
            repeat (tokens) begin
               if ($urandom_range(0, 3) == 0) begin
                  len = $urandom_range(1, 3);
                  repeat (len) sig_bytes.push_back(CH_STAR);
               end
               if ($urandom_range(0, 3) == 0) begin
                  sig_bytes.push_back(CH_AGG_OPEN);
                  len = $urandom_range(0, 4);
                  repeat (len) begin
                     do b = 8'($urandom_range(0, 255)); while (b == CH_AGG_CLOSE);
                     sig_bytes.push_back(b);
                  end
                  if ($urandom_range(0, 11) != 0) sig_bytes.push_back(CH_AGG_CLOSE);
               end else begin
                  do b = 8'($urandom_range(0, 255));
                  while (b == CH_STAR || b == CH_AGG_OPEN || b == CH_IDX_OPEN);
                  sig_bytes.push_back(b);
               end
               sufs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
               repeat (sufs) begin
                  sig_bytes.push_back(CH_IDX_OPEN);
                  pick = $urandom_range(0, 19);
                  if (pick < 14) begin
                     add_number($urandom_range(1, 20));
                  end else if (pick < 16) begin
                     add_number($urandom_range(1, COUNT_MAX));
                  end else if (pick == 16) begin
                     add_number(COUNT_MAX);
                  end else if (pick == 17) begin
                     add_number(COUNT_MAX + $urandom_range(1, 1000));
                  end else if (pick == 18) begin
                     sig_bytes.push_back(CH_ZERO);
                     add_number($urandom_range(0, 99));
                  end else if ($urandom_range(0, 1) == 0) begin
                     b = 8'($urandom_range(0, 255));
                     sig_bytes.push_back(b);
                  end
                  if ($urandom_range(0, 15) != 0) sig_bytes.push_back(CH_IDX_CLOSE);
               end
            end
            if ($urandom_range(0, 19) == 0) begin
               b = 8'($urandom_range(0, 255));
               sig_bytes[$urandom_range(0, sig_bytes.size() - 1)] = b;
            end
         end
      end
   endtask

   task automatic test_random_signatures(input int unsigned byte_target);
      begin
         while (sent_bytes < byte_target) begin
            build_random_signature();
            send_signature();
            if ($urandom_range(0, 99) == 0) wait_for_drain();
         end
         wait_for_drain();
      end
   endtask

   initial begin
      reset_scan();
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_plain_tokens();
      test_open_aggregates();
      test_bad_suffixes();
      test_random_signatures(sent_bytes + 1290);
      calm_mode = 1'b1;
      test_random_signatures(sent_bytes + 240);
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $error("%0d expected tokens never arrived", expected_tokens.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("type_signature_tokenizer_core verification clean");
      end else begin
         $display("type_signature_tokenizer_core verification failed");
      end
      $finish;
   end

endmodule
